// File: design/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
// Used by lpd_core, lpd_out_buf and length_prefix_deframer.
// No dependencies.
package lpd_pkg;

  // Parse phase of the incoming byte stream
  typedef enum logic [1:0] {
    PH_LOW     = 2'd0,
    PH_HIGH    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOPPED = 2'd3
  } phase_e;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ABORT   = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_e;

  // Input operation codes
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  localparam int unsigned LenWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam logic [LenWidth-1:0] MaxPayloadReset = 16'hFFFF;

  // One result transaction
  typedef struct packed {
    kind_e                kind;
    logic [ByteWidth-1:0] out_byte;
    logic                 last;
  } result_t;

endpackage

// File: design/length_prefix_deframer.sv
// Length-prefix deframer: 2-byte little-endian header, then payload bytes.
// Results are registered in the output buffer before they appear on the output.
// Throughput: one input transaction per cycle, limited only by the output register
// draining; input is ready whenever that register is empty or being taken.
// Reset: phase to header-low, counters cleared, max_payload to 65535, output empty.
module length_prefix_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [lpd_pkg::ByteWidth-1:0] data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [lpd_pkg::ByteWidth-1:0] out_byte_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpd_pkg::LenWidth-1:0]  cfg_max_payload_i
);

  logic             accept;
  logic             res_valid;
  logic             space;
  lpd_pkg::result_t res_core;
  lpd_pkg::result_t res_out;
  lpd_pkg::phase_e  phase;

  assign in_ready_o  = space;
  assign accept      = in_valid_i && space;
  assign cfg_ready_o = 1'b1;

  lpd_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .op_i              (lpd_pkg::op_e'(op_i)),
    .data_byte_i       (data_byte_i),
    .cfg_we_i          (cfg_valid_i),
    .cfg_max_payload_i (cfg_max_payload_i),
    .res_valid_o       (res_valid),
    .res_o             (res_core),
    .phase_o           (phase)
  );

  lpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_core),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .space_o     (space),
    .res_o       (res_out)
  );

  assign kind_o     = res_out.kind;
  assign out_byte_o = res_out.out_byte;
  assign last_o     = res_out.last;

  // Once stopped by a too-long header, the parser stays stopped
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase == lpd_pkg::PH_STOPPED |=> phase == lpd_pkg::PH_STOPPED)
    else $error("deframer left stopped phase");

  // A too-long result puts the parser into the stopped phase
  a_toolong_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_core.kind == lpd_pkg::KIND_TOOLONG |=> phase == lpd_pkg::PH_STOPPED)
    else $error("too-long result without stop");

  // Last mark only on payload bytes and empty packets
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |->
      kind_o == lpd_pkg::KIND_BYTE || kind_o == lpd_pkg::KIND_EMPTY)
    else $error("last set on wrong result kind");

  // Non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != lpd_pkg::KIND_BYTE |-> out_byte_o == '0)
    else $error("nonzero byte on non-payload result");

endmodule

// File: design/lpd_core.sv
// Header parser and payload counter of the length-prefix deframer.
// Holds phase, length and max_payload state; forms at most one result per transaction.
// Depends on lpd_pkg.
module lpd_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  lpd_pkg::op_e                          op_i,
  input  logic [lpd_pkg::ByteWidth-1:0]         data_byte_i,
  input  logic                                  cfg_we_i,
  input  logic [lpd_pkg::LenWidth-1:0]          cfg_max_payload_i,
  output logic                                  res_valid_o,
  output lpd_pkg::result_t                      res_o,
  output lpd_pkg::phase_e                       phase_o
);

  lpd_pkg::phase_e                   phase_q, phase_d;
  logic [lpd_pkg::ByteWidth-1:0]     length_low_q, length_low_d;
  logic [lpd_pkg::LenWidth-1:0]      remaining_q, remaining_d;
  logic                              started_q, started_d;
  logic [lpd_pkg::LenWidth-1:0]      max_payload_q;
  logic [lpd_pkg::LenWidth-1:0]      len;
  logic                              is_last;

  assign len     = {data_byte_i, length_low_q};
  assign is_last = (remaining_q <= lpd_pkg::LenWidth'(1));

  // Next state and result for the transaction at the input
  always_comb begin
    phase_d           = phase_q;
    length_low_d      = length_low_q;
    remaining_d       = remaining_q;
    started_d         = started_q;
    res_valid_o       = 1'b0;
    res_o.kind        = lpd_pkg::KIND_BYTE;
    res_o.out_byte    = '0;
    res_o.last        = 1'b0;
    if (phase_q == lpd_pkg::PH_STOPPED) begin
      // ignore everything until reset
    end else if (op_i == lpd_pkg::OP_FLUSH) begin
      // drop partial frame; abort if payload already went out
      phase_d      = lpd_pkg::PH_LOW;
      length_low_d = '0;
      remaining_d  = '0;
      started_d    = 1'b0;
      if (phase_q == lpd_pkg::PH_PAYLOAD && started_q) begin
        res_valid_o = 1'b1;
        res_o.kind  = lpd_pkg::KIND_ABORT;
      end
    end else begin
      case (phase_q)
        lpd_pkg::PH_LOW: begin
          length_low_d = data_byte_i;
          phase_d      = lpd_pkg::PH_HIGH;
        end
        lpd_pkg::PH_HIGH: begin
          length_low_d = '0;
          if (len > max_payload_q) begin
            phase_d     = lpd_pkg::PH_STOPPED;
            res_valid_o = 1'b1;
            res_o.kind  = lpd_pkg::KIND_TOOLONG;
          end else if (len == '0) begin
            phase_d     = lpd_pkg::PH_LOW;
            res_valid_o = 1'b1;
            res_o.kind  = lpd_pkg::KIND_EMPTY;
            res_o.last  = 1'b1;
          end else begin
            remaining_d = len;
            started_d   = 1'b0;
            phase_d     = lpd_pkg::PH_PAYLOAD;
          end
        end
        default: begin
          // pass one payload byte, mark the final one
          res_valid_o    = 1'b1;
          res_o.kind     = lpd_pkg::KIND_BYTE;
          res_o.out_byte = data_byte_i;
          res_o.last     = is_last;
          if (is_last) begin
            remaining_d = '0;
            started_d   = 1'b0;
            phase_d     = lpd_pkg::PH_LOW;
          end else begin
            remaining_d = remaining_q - lpd_pkg::LenWidth'(1);
            started_d   = 1'b1;
          end
        end
      endcase
    end
    if (!accept_i) begin
      res_valid_o = 1'b0;
    end
  end

  // Advance parse state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lpd_pkg::PH_LOW;
      length_low_q <= '0;
      remaining_q  <= '0;
      started_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      length_low_q <= length_low_d;
      remaining_q  <= remaining_d;
      started_q    <= started_d;
    end
  end

  // Hold the configured maximum length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= lpd_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_max_payload_i;
    end
  end

  assign phase_o = phase_q;

endmodule

// File: design/lpd_out_buf.sv
// Output result register of the length-prefix deframer.
// Holds one result until the downstream side takes it.
// Depends on lpd_pkg.
module lpd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  lpd_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             space_o,
  output lpd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  lpd_pkg::result_t res_q;

  // Free when empty or emptied this cycle
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
